### design/spmc_pkg.sv
package spmc_pkg;

	localparam int PAT_MAX = 64;
	localparam int IDX_W   = 6;
	localparam int LEN_W   = 7;
	localparam int CHAR_W  = 8;
	localparam int CNT_W   = 32;
	localparam int SHF_W   = $clog2(PAT_MAX);

	typedef logic [1:0] req_t;
	localparam req_t REQ_LOAD  = 2'd0;
	localparam req_t REQ_TEXT  = 2'd1;
	localparam req_t REQ_CLEAR = 2'd2;

	// per-cell control, driven by the top level
	typedef struct packed {
		logic shift;
		logic clear;
		logic realign;
		logic is_last;
		logic active;
		logic pat_we;
	} cell_ctl_t;

	// word between compare stage and tally stage
	typedef struct packed {
		logic found;
		logic clear;
	} s1_t;

	function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] v);
		logic [LEN_W-1:0] r;
		r = v;
		if (v == '0) r = LEN_W'(1);
		if (v > LEN_W'(PAT_MAX)) r = LEN_W'(PAT_MAX);
		return r;
	endfunction

endpackage

### design/spmc_cell.sv
module spmc_cell (
	input  logic                      clk,
	input  logic                      arst_n,
	input  spmc_pkg::cell_ctl_t       ctl,
	input  logic [spmc_pkg::CHAR_W-1:0] byte_in,
	input  logic [spmc_pkg::CHAR_W-1:0] w_in,
	input  logic [spmc_pkg::CHAR_W-1:0] v_nb,
	input  logic [spmc_pkg::CHAR_W-1:0] v_init,
	output logic [spmc_pkg::CHAR_W-1:0] w_out,
	output logic [spmc_pkg::CHAR_W-1:0] v_out,
	output logic                      eq
);
	import spmc_pkg::*;

	// w_q: plain window byte (newest at cell 0)
	// v_q: window byte aligned to pattern position of this cell
	// p_q: pattern byte
	logic [CHAR_W-1:0] w_q;
	logic [CHAR_W-1:0] v_q;
	logic [CHAR_W-1:0] p_q;
	logic [CHAR_W-1:0] v_next;

	// the last active cell takes the incoming byte, the others take their neighbor
	assign v_next = ctl.is_last ? byte_in : v_nb;
	assign eq     = !ctl.active || (v_next == p_q);
	assign w_out  = w_q;
	assign v_out  = v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= '0;
			v_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				w_q <= '0;
				v_q <= '0;
			end else if (ctl.realign) begin
				v_q <= v_init;
			end else if (ctl.shift) begin
				w_q <= w_in;
				v_q <= v_next;
			end else begin
				// hold
				w_q <= w_q;
				v_q <= v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pat_we) begin
			p_q <= byte_in;
		end
	end

endmodule

### design/spmc_tally.sv
module spmc_tally (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  spmc_pkg::s1_t              item,
	input  logic                       out_ready,
	output logic                       free,
	output logic                       out_valid,
	output logic                       match_found,
	output logic [spmc_pkg::CNT_W-1:0] match_count
);
	import spmc_pkg::*;

	logic             out_v_q;
	logic             found_q;
	logic [CNT_W-1:0] out_cnt_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;

	assign free        = !out_v_q || out_ready;
	assign out_valid   = out_v_q;
	assign match_found = found_q;
	assign match_count = out_cnt_q;

	// saturate at all ones
	always_comb begin
		count_nxt = count_q;
		if (item.clear) begin
			count_nxt = '0;
		end else if (item.found && (count_q != '1)) begin
			count_nxt = count_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (free) begin
				out_v_q <= take;
			end
			if (take) begin
				count_q <= count_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			found_q   <= item.found;
			out_cnt_q <= count_nxt;
		end
	end

	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q && !out_ready |=> out_v_q && $stable(out_cnt_q))
		else $error("result word lost while stalled");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		take && item.clear |=> count_q == '0 && out_cnt_q == '0)
		else $error("clear did not zero the count");

	a_monotone: assert property (@(posedge clk) disable iff (!arst_n)
		take && !item.clear |=> count_q >= $past(count_q))
		else $error("count went down without clear");

endmodule

### design/streaming_pattern_match_counter.sv
// Streaming exact pattern matcher. Load words write pattern bytes by index, text words
// shift one byte into a chain of PAT_MAX cells, clear words zero the window and the
// count. Every input word yields one result word: match_found and the saturating
// match_count after that word. One input word is accepted per cycle unless a stalled
// result holds the compare stage; each cell compares its window byte to its pattern byte
// in parallel, so the rate is set by the cell chain, not by the pattern length. A result
// is offered once its word has passed the compare register (loaded at the accepting
// edge) and the count register (loaded when the output is free). cfg_data holds
// pattern_length; write it only while no word is in flight. A write realigns the window.
module streaming_pattern_match_counter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [1:0]                  req_type,
	input  logic [spmc_pkg::IDX_W-1:0]  pattern_index,
	input  logic [spmc_pkg::CHAR_W-1:0] char_value,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        match_found,
	output logic [spmc_pkg::CNT_W-1:0]  match_count,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [spmc_pkg::LEN_W-1:0]  cfg_data
);
	import spmc_pkg::*;

	logic [LEN_W-1:0] len_q;
	logic [LEN_W-1:0] len_eff;
	logic [LEN_W-1:0] len_new;
	logic [LEN_W-1:0] fill_q;
	logic [LEN_W-1:0] fill_inc;
	logic [LEN_W-1:0] shf_full;
	logic [SHF_W-1:0] shf;

	logic acc;
	logic acc_load;
	logic acc_text;
	logic acc_clear;
	logic cfg_acc;
	logic found_c;

	logic  s1_v_q;
	s1_t   item_s1;
	s1_t   item_c;
	logic  tally_free;
	logic  take;

	cell_ctl_t         ctl    [PAT_MAX];
	logic [CHAR_W-1:0] w_in   [PAT_MAX];
	logic [CHAR_W-1:0] w_out  [PAT_MAX];
	logic [CHAR_W-1:0] v_nb   [PAT_MAX];
	logic [CHAR_W-1:0] v_out  [PAT_MAX];
	logic [CHAR_W-1:0] v_init [PAT_MAX];
	logic [PAT_MAX-1:0] eq;

	logic [PAT_MAX*CHAR_W-1:0] wr_flat;
	logic [PAT_MAX*CHAR_W-1:0] wr_shf;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;
	assign in_ready  = !s1_v_q || tally_free;
	assign acc       = in_valid && in_ready;
	assign acc_load  = acc && (req_type == REQ_LOAD);
	assign acc_text  = acc && (req_type == REQ_TEXT);
	assign acc_clear = acc && (req_type == REQ_CLEAR);
	assign take      = s1_v_q && tally_free;

	assign len_eff = eff_len(len_q);
	assign len_new = eff_len(cfg_data);

	// realign: aligned cell j takes window byte (len_new-1-j), a reversed and shifted view
	assign shf_full = LEN_W'(PAT_MAX) - len_new;
	assign shf      = shf_full[SHF_W-1:0];

	always_comb begin
		for (int m = 0; m < PAT_MAX; m++) begin
			wr_flat[m*CHAR_W +: CHAR_W] = w_out[PAT_MAX-1-m];
		end
	end

	assign wr_shf = wr_flat >> {shf, 3'b000};

	always_comb begin
		for (int j = 0; j < PAT_MAX; j++) begin
			ctl[j].shift   = acc_text;
			ctl[j].clear   = acc_clear;
			ctl[j].realign = cfg_acc;
			ctl[j].is_last = (len_eff == LEN_W'(j + 1));
			ctl[j].active  = (LEN_W'(j) < len_eff);
			ctl[j].pat_we  = acc_load && (pattern_index == IDX_W'(j));
			v_init[j]      = wr_shf[j*CHAR_W +: CHAR_W];
			w_in[j]        = (j == 0) ? char_value : w_out[(j == 0) ? 0 : j - 1];
			v_nb[j]        = (j == PAT_MAX - 1) ? '0 : v_out[(j == PAT_MAX - 1) ? j : j + 1];
		end
	end

	for (genvar g = 0; g < PAT_MAX; g++) begin : g_cell
		spmc_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl     (ctl[g]),
			.byte_in (char_value),
			.w_in    (w_in[g]),
			.v_nb    (v_nb[g]),
			.v_init  (v_init[g]),
			.w_out   (w_out[g]),
			.v_out   (v_out[g]),
			.eq      (eq[g])
		);
	end

	// hold fill at PAT_MAX
	assign fill_inc = (fill_q < LEN_W'(PAT_MAX)) ? fill_q + LEN_W'(1) : fill_q;
	assign found_c  = acc_text && (&eq) && (fill_inc >= len_eff);

	always_comb begin
		item_c.found = found_c;
		item_c.clear = acc_clear;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q  <= LEN_W'(1);
			fill_q <= '0;
			s1_v_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				len_q <= cfg_data;
			end
			if (acc_clear) begin
				fill_q <= '0;
			end else if (acc_text) begin
				fill_q <= fill_inc;
			end
			if (in_ready) begin
				s1_v_q <= in_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			item_s1 <= item_c;
		end
	end

	spmc_tally u_tally (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.item        (item_s1),
		.out_ready   (out_ready),
		.free        (tally_free),
		.out_valid   (out_valid),
		.match_found (match_found),
		.match_count (match_count)
	);

	a_fill_clear: assert property (@(posedge clk) disable iff (!arst_n)
		acc_clear |=> fill_q == '0)
		else $error("clear did not empty the window");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		acc_text && (fill_q < LEN_W'(PAT_MAX)) |=> fill_q == $past(fill_q) + LEN_W'(1))
		else $error("window fill did not advance");

	a_fill_cap: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= LEN_W'(PAT_MAX))
		else $error("window fill beyond capacity");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v_q && !tally_free |=> s1_v_q && $stable(item_s1))
		else $error("compare stage word dropped while stalled");

endmodule

### bench/tb_top.sv
module tb_top;
	import spmc_pkg::*;

	localparam req_t REQ_NOP = 2'd3;	// unused code, must leave all state alone
	localparam int LIMIT = 400000;
	localparam int PHASES = 12;
	localparam int PHASE_WORDS = 110;

	typedef struct packed {
		logic             found;
		logic [CNT_W-1:0] count;
	} tally_t;

	typedef struct {
		req_t              rq;
		logic [IDX_W-1:0]  idx;
		logic [CHAR_W-1:0] ch;
		bit                fixed;
		logic              found;
		logic [CNT_W-1:0]  count;
	} dir_row_t;

	logic                clk;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          req_type;
	logic [IDX_W-1:0]    pattern_index;
	logic [CHAR_W-1:0]   char_value;
	logic                out_valid;
	logic                out_ready;
	logic                match_found;
	logic [CNT_W-1:0]    match_count;
	logic                cfg_valid;
	logic                cfg_ready;
	logic [LEN_W-1:0]    cfg_data;

	// matcher model state
	logic [CHAR_W-1:0]   pat_mem [PAT_MAX];
	logic [CHAR_W-1:0]   win [PAT_MAX];
	int unsigned         fill;
	logic [CNT_W-1:0]    total;
	logic [LEN_W-1:0]    len_reg;

	tally_t              tally_q [$];
	logic [CHAR_W-1:0]   burst_q [$];
	int                  errors;
	int                  cycles;
	int                  idle_pct;
	int                  stall_pct;
	bit                  squeeze;

	dir_row_t dir_rows [16] = '{
		'{REQ_LOAD,  6'd0,  8'h41, 1'b1, 1'b0, 32'd0},
		'{REQ_LOAD,  6'd63, 8'hFF, 1'b1, 1'b0, 32'd0},
		'{REQ_LOAD,  6'd42, 8'h00, 1'b1, 1'b0, 32'd0},
		'{REQ_TEXT,  6'd21, 8'h41, 1'b1, 1'b1, 32'd1},
		'{REQ_TEXT,  6'd42, 8'h41, 1'b1, 1'b1, 32'd2},
		'{REQ_TEXT,  6'd0,  8'h00, 1'b1, 1'b0, 32'd2},
		'{REQ_TEXT,  6'd63, 8'hFF, 1'b1, 1'b0, 32'd2},
		'{REQ_NOP,   6'd21, 8'hAA, 1'b1, 1'b0, 32'd2},
		'{REQ_TEXT,  6'd0,  8'h41, 1'b1, 1'b1, 32'd3},
		'{REQ_CLEAR, 6'd0,  8'h00, 1'b1, 1'b0, 32'd0},
		'{REQ_TEXT,  6'd0,  8'h41, 1'b1, 1'b1, 32'd1},
		// swap the pattern byte mid-stream
		'{REQ_LOAD,  6'd0,  8'h55, 1'b0, 1'b0, 32'd0},
		'{REQ_TEXT,  6'd0,  8'h41, 1'b0, 1'b0, 32'd0},
		'{REQ_TEXT,  6'd0,  8'h55, 1'b0, 1'b0, 32'd0},
		'{REQ_CLEAR, 6'd63, 8'hFF, 1'b1, 1'b0, 32'd0},
		'{REQ_NOP,   6'd0,  8'h00, 1'b1, 1'b0, 32'd0}
	};

	logic [LEN_W-1:0] len_plan [PHASES] = '{
		7'd1, 7'd0, 7'd2, 7'd3, 7'd64, 7'd127, 7'd65, 7'd4, 7'd6, 7'd2, 7'd1, 7'd8
	};

	streaming_pattern_match_counter dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.req_type      (req_type),
		.pattern_index (pattern_index),
		.char_value    (char_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.match_found   (match_found),
		.match_count   (match_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic int span();
		int n;
		n = len_reg;
		if (n == 0) n = 1;
		if (n > PAT_MAX) n = PAT_MAX;
		return n;
	endfunction

	function automatic logic [CHAR_W-1:0] pick_letter();
		int r;
		r = $urandom_range(99);
		if (r < 45) return 8'h61;
		if (r < 90) return 8'h62;
		return 8'h23;
	endfunction

	function automatic tally_t count_matches(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [CHAR_W-1:0] ch);
		tally_t t;
		int n;
		t.found = 1'b0;
		n = span();
		case (rq)
			REQ_LOAD: begin
				pat_mem[ix] = ch;
			end
			REQ_TEXT: begin
				for (int k = PAT_MAX - 1; k > 0; k--)
					win[k] = win[k-1];
				win[0] = ch;
				if (fill < PAT_MAX) fill++;
				if (fill >= n) begin
					t.found = 1'b1;
					// newest byte lines up with the last pattern byte
					for (int k = 0; k < n; k++)
						if (win[k] != pat_mem[n-1-k]) t.found = 1'b0;
				end
				if (t.found && total != '1) total++;
			end
			REQ_CLEAR: begin
				for (int k = 0; k < PAT_MAX; k++)
					win[k] = '0;
				fill = 0;
				total = '0;
			end
			default: ;
		endcase
		t.count = total;
		return t;
	endfunction

	task automatic send_word(input req_t rq, input logic [IDX_W-1:0] ix,
			input logic [CHAR_W-1:0] ch, input bit fixed, input tally_t want);
		tally_t t;
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq;
		pattern_index <= ix;
		char_value <= ch;
		do @(posedge clk); while (!in_ready);
		t = count_matches(rq, ix, ch);
		tally_q.push_back(fixed ? want : t);
	endtask

	task automatic wait_quiet();
		while (tally_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_len(input logic [LEN_W-1:0] v);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		len_reg = v;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		int r;
		int n;
		req_t rq;
		logic [IDX_W-1:0] ix;
		logic [CHAR_W-1:0] ch;
		tally_t want;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = REQ_LOAD;
		pattern_index = '0;
		char_value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		idle_pct = 32;
		stall_pct = 32;
		squeeze = 1'b0;
		for (int k = 0; k < PAT_MAX; k++) begin
			pat_mem[k] = '0;
			win[k] = '0;
		end
		fill = 0;
		total = '0;
		len_reg = 7'd1;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) begin
			want.found = dir_rows[i].found;
			want.count = dir_rows[i].count;
			send_word(dir_rows[i].rq, dir_rows[i].idx, dir_rows[i].ch, dir_rows[i].fixed, want);
		end

		// fill the whole store so any length compares only written bytes
		for (int k = 0; k < PAT_MAX; k++)
			send_word(REQ_LOAD, IDX_W'(k), pick_letter(), 1'b0, '0);

		for (int ph = 0; ph < PHASES; ph++) begin
			@(negedge clk);
			in_valid <= 1'b0;
			wait_quiet();
			write_len((ph == 8) ? LEN_W'($urandom_range(64, 1)) : len_plan[ph]);
			idle_pct = (ph == 3) ? 0 : 32;
			stall_pct = idle_pct;
			if (ph == 2) squeeze = 1'b1;
			n = span();
			burst_q.delete();
			for (int w = 0; w < PHASE_WORDS; w++) begin
				ix = IDX_W'($urandom_range(63));
				ch = pick_letter();
				rq = REQ_TEXT;
				if (burst_q.size() != 0) begin
					ch = burst_q.pop_front();
				end else begin
					r = $urandom_range(99);
					if (r < 8) begin
						rq = REQ_LOAD;
						if ($urandom_range(3) != 0) ix = IDX_W'($urandom_range(n - 1));
						if ($urandom_range(4) == 0) ch = CHAR_W'($urandom_range(255));
					end else if (r < 11) begin
						rq = REQ_CLEAR;
					end else if (r < 13) begin
						rq = REQ_NOP;
						ch = CHAR_W'($urandom_range(255));
					end else if (r < 19) begin
						// replay the live pattern so long lengths still hit
						for (int k = 0; k < n; k++)
							burst_q.push_back(pat_mem[k]);
						ch = burst_q.pop_front();
					end else if (r < 23) begin
						ch = CHAR_W'($urandom_range(255));
					end
				end
				send_word(rq, ix, ch, 1'b0, '0);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		wait_quiet();
		repeat (4) @(posedge clk);
		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	// result side: random stalls plus one long hold-off
	initial begin : drain_side
		int hold_left;
		hold_left = 0;
		out_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (squeeze && hold_left == 0) begin
				hold_left = 300;
				squeeze = 1'b0;
			end
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left--;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	always @(posedge clk) begin : check_results
		tally_t want;
		if (arst_n && out_valid && out_ready) begin
			if (tally_q.size() == 0) begin
				$display("%0t: unexpected word: expected none, got found=%0b count=%0d",
					$time, match_found, match_count);
				errors++;
			end else begin
				want = tally_q.pop_front();
				if (match_found !== want.found) begin
					$display("%0t: match_found mismatch: expected %0b, got %0b",
						$time, want.found, match_found);
					errors++;
				end
				if (match_count !== want.count) begin
					$display("%0t: match_count mismatch: expected %0d, got %0d",
						$time, want.count, match_count);
					errors++;
				end
			end
		end
	end

	initial cycles = 0;
	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("%0t: timeout with %0d words outstanding", $time, tally_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

endmodule

### filelist.f
design/spmc_pkg.sv
design/spmc_cell.sv
design/spmc_tally.sv
design/streaming_pattern_match_counter.sv
bench/tb_top.sv
